// File: hdl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// Used by every module in hdl/; depends on nothing.
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int DW  = DATA_WIDTH;
    localparam int PW  = 2 * DW;          // full product width
    localparam int SW  = PW + 1;          // signed sum of two products
    localparam int MW  = PW;              // magnitude of such a sum
    localparam int XW  = MW + FRAC_BITS;  // dividend after the fraction shift
    localparam int QB  = DW + 1;          // quotient bits the divider develops
    localparam int RW  = PW + 1;          // partial remainder width
    localparam int CW  = QB + 1;          // quotient magnitude after rounding

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic signed [DW-1:0] a_real;
        logic signed [DW-1:0] a_imag;
        logic signed [DW-1:0] b_real;
        logic signed [DW-1:0] b_imag;
    } in_item_t;

    typedef struct packed {
        logic signed [DW-1:0] res_real;
        logic signed [DW-1:0] res_imag;
        logic                 overflow;
        logic                 div_zero;
    } out_item_t;

    // Classified item as it waits between front and back
    typedef struct packed {
        op_t      op;
        logic     dz;
        in_item_t item;
    } q_entry_t;

    // Side information that rides along the divider
    typedef struct packed {
        logic          is_div;
        logic          dz;
        logic          neg_re;
        logic          neg_im;
        logic          huge_re;
        logic          huge_im;
        logic [DW-1:0] early_re;
        logic [DW-1:0] early_im;
        logic          early_ovf;
    } div_tag_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] lo;
        logic [QB-1:0] q;
    } part_t;

    typedef struct packed {
        div_tag_t      tag;
        part_t         re;
        part_t         im;
        logic [PW-1:0] den;
    } div_stage_t;

endpackage

// File: hdl/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front, queue and back joined.
// Depends on cau_pkg, cau_front, cau_queue, cau_divider and cau_back.
//
//  channel   | handshake        | payload               | direction
//  ----------+------------------+-----------------------+----------
//  operands  | push / full      | operand (in_item_t)   | in
//  results   | pop / empty      | result (out_item_t)   | out
//
// One transaction is accepted per cycle while full is low, and one result leaves per
// cycle while results are ready and popped. A result passes through the front register,
// queue, three arithmetic stages, divider input register, DATA_WIDTH + 1 quotient
// stages, rounding and output.
// Every opcode runs the same path so results stay in order.
// Reset clears the valid bits, queue pointers and counts only.
// While a result is not popped the back pipeline holds as a whole; the
// queue and front register keep filling until full rises.
module complex_arithmetic_unit_core import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  in_item_t  operand,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic     q_wr;
    q_entry_t q_wdata;
    logic     q_full;
    logic     q_rd;
    q_entry_t q_rdata;
    logic     q_empty;

    // Front: take a transaction and tag its operation
    cau_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .operand (operand),
        .full    (full),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_data  (q_wdata)
    );

    // Queue: decouple the front from back-pressure in the pipeline
    cau_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back: multiply, combine, divide, saturate
    cau_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// File: hdl/cau_front.sv
// Front stage: registers an incoming operand set and classifies it.
// Depends on cau_pkg.
module cau_front import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t operand,
    output logic     full,
    input  logic     q_full,
    output logic     q_wr,
    output q_entry_t q_data
);

    logic     valid_reg;
    q_entry_t ent_reg;
    q_entry_t ent_next;
    logic     accept;

    assign q_wr   = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_data = ent_reg;

    always_comb
    begin
        ent_next.item = operand;
        ent_next.op   = op_t'(operand.opcode);
        ent_next.dz   = (op_t'(operand.opcode) == OP_DIV) &&
                        (operand.b_real == '0) && (operand.b_imag == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (q_wr)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ent_reg <= ent_next;
    end

endmodule

// File: hdl/cau_queue.sv
// Short queue of classified items between front and back.
// Depends on cau_pkg.
module cau_queue import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  q_entry_t wdata,
    output logic     full,
    input  logic     rd,
    output q_entry_t rdata,
    output logic     empty
);

    q_entry_t         mem [QDEPTH];
    logic [QAW-1:0]   wp_reg;
    logic [QAW-1:0]   rp_reg;
    logic [QCW-1:0]   cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (cnt_reg == QCW'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + QAW'(1);
            if (do_rd)
                rp_reg <= rp_reg + QAW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + QCW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - QCW'(1);
        end
    end

endmodule

// File: hdl/cau_divider.sv
// Pipelined restoring divider, one quotient bit per stage, both parts at once.
// Depends on cau_pkg.
module cau_divider import cau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  div_stage_t in_data,
    output logic       out_valid,
    output div_stage_t out_data
);

    div_stage_t stage_reg [QB+1];
    logic       valid_reg [QB+1];

    function automatic part_t pstep(input part_t p, input logic [PW-1:0] den);
        logic [RW-1:0] r;
        logic [RW-1:0] d;
        part_t         o;
        r = {p.rem[RW-2:0], p.lo[QB-1]};
        d = {1'b0, den};
        o = p;
        o.lo = {p.lo[QB-2:0], 1'b0};
        if (r >= d)
        begin
            o.rem = r - d;
            o.q   = {p.q[QB-2:0], 1'b1};
        end
        else
        begin
            o.rem = r;
            o.q   = {p.q[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            stage_reg[0] <= in_data;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k+1].tag <= stage_reg[k].tag;
                stage_reg[k+1].den <= stage_reg[k].den;
                stage_reg[k+1].re  <= pstep(stage_reg[k].re, stage_reg[k].den);
                stage_reg[k+1].im  <= pstep(stage_reg[k].im, stage_reg[k].den);
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_data  = stage_reg[QB];

endmodule

// File: hdl/cau_back.sv
// Back part: products, sums, saturation and the divide path.
// Depends on cau_pkg and cau_divider.
module cau_back import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  q_entry_t  q_data,
    output logic      q_pop,
    output out_item_t result,
    output logic      empty,
    input  logic      pop
);

    typedef struct packed {
        logic [DW-1:0] val;
        logic          ovf;
    } sat_t;

    typedef struct packed {
        op_t                  op;
        logic                 dz;
        logic signed [DW-1:0] ar;
        logic signed [DW-1:0] ai;
        logic signed [DW-1:0] br;
        logic signed [DW-1:0] bi;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] s_rr;
        logic signed [PW-1:0] s_ii;
    } b1_t;

    typedef struct packed {
        op_t                  op;
        logic                 dz;
        logic signed [SW-1:0] v_re;
        logic signed [SW-1:0] v_im;
        logic [PW-1:0]        den;
    } b2_t;

    typedef struct packed {
        div_tag_t      tag;
        logic [MW-1:0] mag_re;
        logic [MW-1:0] mag_im;
        logic [PW-1:0] den;
    } b3_t;

    typedef struct packed {
        div_tag_t      tag;
        logic [CW-1:0] mag_re;
        logic [CW-1:0] mag_im;
    } f1_t;

    localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic [CW-1:0] M_POS = (CW'(1) << (DW - 1)) - CW'(1);
    localparam logic [CW-1:0] M_NEG = CW'(1) << (DW - 1);
    localparam logic [QB-1:0] Q_CAP = QB'(1) << DW;

    function automatic sat_t sat_s(input logic signed [SW-1:0] v);
        sat_t s;
        if (v > SAT_HI)
        begin
            s.val = SAT_HI[DW-1:0];
            s.ovf = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            s.val = SAT_LO[DW-1:0];
            s.ovf = 1'b1;
        end
        else
        begin
            s.val = v[DW-1:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction

    function automatic sat_t sat_sm(input logic neg, input logic [CW-1:0] mag);
        sat_t          s;
        logic [CW-1:0] nmag;
        nmag = CW'(0) - mag;
        s.ovf = 1'b0;
        if (!neg)
        begin
            if (mag > M_POS)
            begin
                s.val = M_POS[DW-1:0];
                s.ovf = 1'b1;
            end
            else
                s.val = mag[DW-1:0];
        end
        else
        begin
            if (mag > M_NEG)
            begin
                s.val = M_NEG[DW-1:0];
                s.ovf = 1'b1;
            end
            else
                s.val = nmag[DW-1:0];
        end
        return s;
    endfunction

    logic       en;
    logic       b1_valid_reg;
    logic       b2_valid_reg;
    logic       b3_valid_reg;
    logic       f1_valid_reg;
    logic       out_valid_reg;
    b1_t        b1_reg;
    b1_t        b1_next;
    b2_t        b2_reg;
    b2_t        b2_next;
    b3_t        b3_reg;
    b3_t        b3_next;
    f1_t        f1_reg;
    f1_t        f1_next;
    out_item_t  out_reg;
    out_item_t  out_next;
    div_stage_t div_in;
    div_stage_t div_out;
    logic       div_valid;

    // Whole pipeline moves together; hold it while the result sits untaken
    assign en     = !out_valid_reg || pop;
    assign q_pop  = en && !q_empty;
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // Stage 1: all six products
    logic signed [DW-1:0] ar;
    logic signed [DW-1:0] ai;
    logic signed [DW-1:0] br;
    logic signed [DW-1:0] bi;

    always_comb
    begin
        ar = q_data.item.a_real;
        ai = q_data.item.a_imag;
        br = q_data.item.b_real;
        bi = q_data.item.b_imag;
        b1_next.op   = q_data.op;
        b1_next.dz   = q_data.dz;
        b1_next.ar   = ar;
        b1_next.ai   = ai;
        b1_next.br   = br;
        b1_next.bi   = bi;
        b1_next.p_rr = PW'(ar) * PW'(br);
        b1_next.p_ii = PW'(ai) * PW'(bi);
        b1_next.p_ir = PW'(ai) * PW'(br);
        b1_next.p_ri = PW'(ar) * PW'(bi);
        b1_next.s_rr = PW'(br) * PW'(br);
        b1_next.s_ii = PW'(bi) * PW'(bi);
    end

    // Stage 2: one add or subtract per part, divisor squared magnitude
    logic signed [SW-1:0] x_re;
    logic signed [SW-1:0] y_re;
    logic signed [SW-1:0] x_im;
    logic signed [SW-1:0] y_im;
    logic                 sub_re;
    logic                 sub_im;

    always_comb
    begin
        unique case (b1_reg.op)
            OP_ADD:
            begin
                x_re = SW'(b1_reg.ar);   y_re = SW'(b1_reg.br);   sub_re = 1'b0;
                x_im = SW'(b1_reg.ai);   y_im = SW'(b1_reg.bi);   sub_im = 1'b0;
            end
            OP_SUB:
            begin
                x_re = SW'(b1_reg.ar);   y_re = SW'(b1_reg.br);   sub_re = 1'b1;
                x_im = SW'(b1_reg.ai);   y_im = SW'(b1_reg.bi);   sub_im = 1'b1;
            end
            OP_MUL:
            begin
                x_re = SW'(b1_reg.p_rr); y_re = SW'(b1_reg.p_ii); sub_re = 1'b1;
                x_im = SW'(b1_reg.p_ir); y_im = SW'(b1_reg.p_ri); sub_im = 1'b0;
            end
            OP_DIV:
            begin
                x_re = SW'(b1_reg.p_rr); y_re = SW'(b1_reg.p_ii); sub_re = 1'b0;
                x_im = SW'(b1_reg.p_ir); y_im = SW'(b1_reg.p_ri); sub_im = 1'b1;
            end
            default:
            begin
                x_re = '0; y_re = '0; sub_re = 1'b0;
                x_im = '0; y_im = '0; sub_im = 1'b0;
            end
        endcase
        b2_next.op   = b1_reg.op;
        b2_next.dz   = b1_reg.dz;
        b2_next.v_re = sub_re ? x_re - y_re : x_re + y_re;
        b2_next.v_im = sub_im ? x_im - y_im : x_im + y_im;
        b2_next.den  = PW'(b1_reg.s_rr) + PW'(b1_reg.s_ii);
    end

    // Stage 3: finish add/sub/mul, split divide numerators into sign and magnitude
    logic signed [SW-1:0] sv_re;
    logic signed [SW-1:0] sv_im;
    sat_t                 es_re;
    sat_t                 es_im;

    always_comb
    begin
        sv_re = (b2_reg.op == OP_MUL) ? (b2_reg.v_re >>> FRAC_BITS) : b2_reg.v_re;
        sv_im = (b2_reg.op == OP_MUL) ? (b2_reg.v_im >>> FRAC_BITS) : b2_reg.v_im;
        es_re = sat_s(sv_re);
        es_im = sat_s(sv_im);
        b3_next.tag.is_div    = (b2_reg.op == OP_DIV);
        b3_next.tag.dz        = b2_reg.dz;
        b3_next.tag.neg_re    = b2_reg.v_re[SW-1];
        b3_next.tag.neg_im    = b2_reg.v_im[SW-1];
        b3_next.tag.huge_re   = 1'b0;
        b3_next.tag.huge_im   = 1'b0;
        b3_next.tag.early_re  = es_re.val;
        b3_next.tag.early_im  = es_im.val;
        b3_next.tag.early_ovf = es_re.ovf || es_im.ovf;
        b3_next.mag_re = b2_reg.v_re[SW-1] ? MW'(-b2_reg.v_re) : MW'(b2_reg.v_re);
        b3_next.mag_im = b2_reg.v_im[SW-1] ? MW'(-b2_reg.v_im) : MW'(b2_reg.v_im);
        b3_next.den    = b2_reg.den;
    end

    // Divider entry: flag quotients too large to matter, seed the remainders
    logic [XW-1:0] x_re_w;
    logic [XW-1:0] x_im_w;
    logic [XW-1:0] hi_re;
    logic [XW-1:0] hi_im;

    always_comb
    begin
        x_re_w = XW'(b3_reg.mag_re) << FRAC_BITS;
        x_im_w = XW'(b3_reg.mag_im) << FRAC_BITS;
        hi_re  = x_re_w >> QB;
        hi_im  = x_im_w >> QB;
        div_in.tag         = b3_reg.tag;
        div_in.tag.huge_re = (hi_re >= XW'(b3_reg.den));
        div_in.tag.huge_im = (hi_im >= XW'(b3_reg.den));
        div_in.den         = b3_reg.den;
        div_in.re.rem      = RW'(hi_re);
        div_in.re.lo       = x_re_w[QB-1:0];
        div_in.re.q        = '0;
        div_in.im.rem      = RW'(hi_im);
        div_in.im.lo       = x_im_w[QB-1:0];
        div_in.im.q        = '0;
    end

    cau_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b3_valid_reg),
        .in_data   (div_in),
        .out_valid (div_valid),
        .out_data  (div_out)
    );

    // Floor rounding of the quotients, clamp runaway ones
    logic big_re;
    logic big_im;

    always_comb
    begin
        big_re = div_out.tag.huge_re || (div_out.re.q > Q_CAP);
        big_im = div_out.tag.huge_im || (div_out.im.q > Q_CAP);
        f1_next.tag    = div_out.tag;
        f1_next.mag_re = big_re ? CW'(Q_CAP) :
                         CW'(div_out.re.q) +
                         CW'(div_out.tag.neg_re && (div_out.re.rem != '0));
        f1_next.mag_im = big_im ? CW'(Q_CAP) :
                         CW'(div_out.im.q) +
                         CW'(div_out.tag.neg_im && (div_out.im.rem != '0));
    end

    // Output stage: saturate the divide result and pick the right one
    sat_t ds_re;
    sat_t ds_im;

    always_comb
    begin
        ds_re = sat_sm(f1_reg.tag.neg_re, f1_reg.mag_re);
        ds_im = sat_sm(f1_reg.tag.neg_im, f1_reg.mag_im);
        if (!f1_reg.tag.is_div)
        begin
            out_next.res_real = f1_reg.tag.early_re;
            out_next.res_imag = f1_reg.tag.early_im;
            out_next.overflow = f1_reg.tag.early_ovf;
            out_next.div_zero = 1'b0;
        end
        else if (f1_reg.tag.dz)
        begin
            out_next.res_real = '0;
            out_next.res_imag = '0;
            out_next.overflow = 1'b0;
            out_next.div_zero = 1'b1;
        end
        else
        begin
            out_next.res_real = ds_re.val;
            out_next.res_imag = ds_im.val;
            out_next.overflow = ds_re.ovf || ds_im.ovf;
            out_next.div_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            f1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg  <= q_pop;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            f1_valid_reg  <= div_valid;
            out_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg  <= b1_next;
            b2_reg  <= b2_next;
            b3_reg  <= b3_next;
            f1_reg  <= f1_next;
            out_reg <= out_next;
        end
    end

endmodule

// File: dv/cau_checker.sv
// Result checker for the complex arithmetic unit: watches both queue ports,
// computes each expected result in fixed point and compares in order.
// Depends on cau_pkg.
module cau_checker import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  operand,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t result,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [127:0] MAXPOS = (128'd1 << (DW - 1)) - 1;
    localparam logic [127:0] MAXNEG = 128'd1 << (DW - 1);

    out_item_t expected_q[$];

    // Clamp a sign/magnitude value to the signed DW-bit range.
    function automatic logic [DW-1:0] clamp(input logic neg, input logic [127:0] mag,
                                            inout logic ovf);
        logic [127:0] t;
        if (!neg)
        begin
            if (mag > MAXPOS)
            begin
                ovf = 1'b1;
                return MAXPOS[DW-1:0];
            end
            return mag[DW-1:0];
        end
        if (mag > MAXNEG)
        begin
            ovf = 1'b1;
            return MAXNEG[DW-1:0];
        end
        t = -mag;
        return t[DW-1:0];
    endfunction

    // Floor of v / 2^FRAC_BITS, or of v * 2^FRAC_BITS / den, as sign and magnitude.
    function automatic logic [DW-1:0] part_of(input logic signed [127:0] v,
                                              input logic [127:0] den,
                                              input logic is_div, inout logic ovf);
        logic          neg;
        logic [127:0]  mag;
        logic [127:0]  q;
        logic          rem;
        neg = v < 0;
        mag = neg ? -v : v;
        if (is_div)
        begin
            q   = (mag << FRAC_BITS) / den;
            rem = ((mag << FRAC_BITS) % den) != 0;
        end
        else
        begin
            q   = mag >> FRAC_BITS;
            rem = (mag & ((128'd1 << FRAC_BITS) - 1)) != 0;
        end
        if (neg && rem)
            q = q + 1;
        if (q == 0)
            neg = 1'b0;
        return clamp(neg, q, ovf);
    endfunction

    function automatic out_item_t complex_result(input in_item_t x);
        out_item_t r;
        logic signed [127:0] ar, ai, br, bi, nre, nim;
        logic [127:0] den;
        logic ovf;
        ar = x.a_real; ai = x.a_imag; br = x.b_real; bi = x.b_imag;
        ovf = 1'b0;
        r = '0;
        case (op_t'(x.opcode))
            OP_ADD:
            begin
                r.res_real = part_of((ar + br) <<< FRAC_BITS, 1, 1'b0, ovf);
                r.res_imag = part_of((ai + bi) <<< FRAC_BITS, 1, 1'b0, ovf);
            end
            OP_SUB:
            begin
                r.res_real = part_of((ar - br) <<< FRAC_BITS, 1, 1'b0, ovf);
                r.res_imag = part_of((ai - bi) <<< FRAC_BITS, 1, 1'b0, ovf);
            end
            OP_MUL:
            begin
                r.res_real = part_of(ar * br - ai * bi, 1, 1'b0, ovf);
                r.res_imag = part_of(ai * br + ar * bi, 1, 1'b0, ovf);
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.div_zero = 1'b1;
                else
                begin
                    nre = ar * br + ai * bi;
                    nim = ai * br - ar * bi;
                    r.res_real = part_of(nre, den, 1'b1, ovf);
                    r.res_imag = part_of(nim, den, 1'b1, ovf);
                end
            end
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (push && !full)
                expected_q.push_back(complex_result(operand));
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.res_real !== result.res_real || want.res_imag !== result.res_imag
                        || want.overflow !== result.overflow
                        || want.div_zero !== result.div_zero)
                    begin
                        $display("%0t: mismatch expected re=%h im=%h ovf=%b dz=%b",
                                 $time, want.res_real, want.res_imag, want.overflow,
                                 want.div_zero);
                        $display("%0t:          actual   re=%h im=%h ovf=%b dz=%b",
                                 $time, result.res_real, result.res_imag, result.overflow,
                                 result.div_zero);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: dv/complex_arithmetic_unit_core_tb.sv
// Testbench top for complex_arithmetic_unit_core: clock, reset, operand
// stimulus, result pop pattern and verdict. Depends on cau_pkg, cau_checker.
module complex_arithmetic_unit_core_tb import cau_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1300;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    logic      empty;
    logic      pop;
    in_item_t  operand;
    out_item_t result;
    int        fail_count;
    int        pending;
    int        op_seen[4];
    bit        stim_done;

    complex_arithmetic_unit_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .operand (operand),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    cau_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .operand    (operand),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Pick one operand part: mostly small Q16.16 values, sometimes
    // the extremes, zero or fully random bit patterns.
    function automatic logic [DW-1:0] pick_part();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(DW-1){1'b1}}};
            1:       return {1'b1, {(DW-1){1'b0}}};
            2:       return '0;
            3, 4:    return $urandom;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    // Hold one transaction until the queue accepts it. Inputs change on the
    // falling edge so the rising edge sees settled values.
    task automatic send(input op_t op, input logic [DW-1:0] ar, input logic [DW-1:0] ai,
                        input logic [DW-1:0] br, input logic [DW-1:0] bi);
        operand <= '{opcode: op, a_real: ar, a_imag: ai, b_real: br, b_imag: bi};
        push    <= 1'b1;
        op_seen[op]++;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    task automatic idle(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Receiver: stalls in runs of random length, with stall-free stretches.
    initial
    begin
        int run;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = $urandom_range(1, 30);
            pop <= ($urandom_range(0, 3) != 0);
            repeat (run) @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        logic [DW-1:0] mx, mn, one;
        int burst;
        int i;
        mx  = {1'b0, {(DW-1){1'b1}}};
        mn  = {1'b1, {(DW-1){1'b0}}};
        one = 1 << FRAC_BITS;
        rst_n   = 1'b0;
        push    = 1'b0;
        operand = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: each opcode, extremes, saturation both ways, zero divisor.
        send(OP_ADD, mx, mn, mx, mn);
        send(OP_ADD, mx, mx, mn, mn);
        send(OP_SUB, mn, mx, mx, mn);
        send(OP_SUB, 0, 0, mn, mn);
        send(OP_SUB, one, -one, one, one);
        send(OP_MUL, mx, mx, mx, mx);
        send(OP_MUL, mn, mn, mn, mn);
        send(OP_MUL, mn, 0, mn, 0);
        send(OP_MUL, -1, 0, 1, 0);
        send(OP_MUL, one, one, one, -one);
        send(OP_DIV, one, one, 0, 0);
        send(OP_DIV, mx, mn, 0, 0);
        send(OP_DIV, mx, mx, 1, 0);
        send(OP_DIV, mn, mn, 0, 1);
        send(OP_DIV, mn, mn, mn, mn);
        send(OP_DIV, -1, 0, mx, 0);
        send(OP_DIV, one, 0, 3 * one, 0);
        send(OP_DIV, mx, mn, mx, mx);
        send(OP_ADD, 0, 0, 0, 0);
        idle(1);

        // Drain completely once before the random part.
        wait (pending == 0);
        @(negedge clk);

        i = 0;
        while (i < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                send(op_t'($urandom_range(0, 3)), pick_part(), pick_part(),
                     pick_part(), pick_part());
                i++;
            end
            if ($urandom_range(0, 2) == 0)
                idle($urandom_range(1, 12));
        end
        push <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        stim_done = 1'b0;
        @(posedge stim_done);
        wait (pending == 0);
        repeat (DW + 20) @(posedge clk);
        $display("Covered %0d add, %0d sub, %0d mul, %0d div transactions",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("with bursty pushes, random pop stalls and saturation cases.");
        if (fail_count == 0)
            $display("complex_arithmetic_unit_core_tb OK");
        else
            $display("complex_arithmetic_unit_core_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("complex_arithmetic_unit_core_tb NOT OK");
        $finish;
    end

endmodule
